// ----- rtl/scaled_seven_segment_row_render_defines.svh -----
// Assertion macros for the seven-segment row renderer checks.
// The enclosing scope must provide i_clk and i_rst_n.
`ifndef SCALED_SEVEN_SEGMENT_ROW_RENDER_DEFINES_SVH
`define SCALED_SEVEN_SEGMENT_ROW_RENDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssr check failed");

// Consequent must hold in the cycle after the antecedent
`define SSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssr check failed");

`endif

// ----- rtl/ssr_pkg.sv -----
`default_nettype none

package ssr_pkg;

    // Default sizes
    localparam int MAX_SIZE_DEF   = 10;
    localparam int MAX_DIGITS_DEF = 8;

    // Slice layout
    localparam int SLICE_CHARS = 12;
    localparam int CHAR_W      = 2;
    localparam int SLICE_W     = SLICE_CHARS * CHAR_W;
    localparam int CODE_DIGITS = 8;

    // Character codes
    typedef logic [CHAR_W-1:0] t_char;
    localparam t_char CH_SPACE = 2'd0;
    localparam t_char CH_DASH  = 2'd1;
    localparam t_char CH_BAR   = 2'd2;

    typedef logic [SLICE_W-1:0] t_slice;

    // Input word
    typedef struct packed {
        logic [31:0] digit_codes;
        logic [3:0]  digit_count;
        logic [4:0]  row_index;
    } t_in_word;

    // Output word
    typedef struct packed {
        t_slice      slice_chars;
        logic [2:0]  digit_position;
        logic        last_slice;
    } t_out_word;

    // Segment bits, bit k: 0 top, 1 upper right, 2 lower right, 3 bottom,
    // 4 lower left, 5 upper left, 6 middle. Non-decimal codes are blank.
    function automatic logic [6:0] seg_map(input logic [3:0] code);
        logic [6:0] seg;
        case (code)
            4'd0:    seg = 7'b0111111;
            4'd1:    seg = 7'b0000110;
            4'd2:    seg = 7'b1011011;
            4'd3:    seg = 7'b1001111;
            4'd4:    seg = 7'b1100110;
            4'd5:    seg = 7'b1101101;
            4'd6:    seg = 7'b1111101;
            4'd7:    seg = 7'b0000111;
            4'd8:    seg = 7'b1111111;
            4'd9:    seg = 7'b1101111;
            default: seg = 7'b0000000;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ssr_lane.sv -----
`default_nettype none

// One digit lane: renders the requested row of one glyph
module ssr_lane (
    input  wire logic [3:0]      i_code,
    input  wire logic [3:0]      i_size,
    input  wire logic [4:0]      i_row,
    output      ssr_pkg::t_slice o_slice
);
    import ssr_pkg::*;

    logic [6:0] seg;
    logic [5:0] s6;
    logic [5:0] r6;
    logic [4:0] s5;
    logic       is_top;
    logic       is_mid;
    logic       is_bot;
    logic       is_horiz;
    logic       is_up;
    logic       is_lo;
    logic       dash_on;
    logic       left_on;
    logic       right_on;

    // Row classification
    always_comb begin
        seg      = seg_map(i_code);
        s6       = {2'b00, i_size};
        r6       = {1'b0, i_row};
        s5       = {1'b0, i_size};
        is_top   = (r6 == 6'd0);
        is_mid   = (r6 == s6 + 6'd1);
        is_bot   = (r6 == {1'b0, i_size, 1'b0} + 6'd2);
        is_horiz = is_top | is_mid | is_bot;
        is_up    = !is_horiz && (r6 <= s6);
        is_lo    = !is_horiz && !is_up && (r6 <= {1'b0, i_size, 1'b0} + 6'd1);
        dash_on  = (is_top & seg[0]) | (is_mid & seg[6]) | (is_bot & seg[3]);
        left_on  = (is_up & seg[5]) | (is_lo & seg[4]);
        right_on = (is_up & seg[1]) | (is_lo & seg[2]);
    end

    // Per-column characters
    always_comb begin
        o_slice = '0;
        for (int j = 0; j < SLICE_CHARS; j++) begin
            if (j == 0 && left_on) begin
                o_slice[CHAR_W*j +: CHAR_W] = CH_BAR;
            end else if (5'(j) == s5 + 5'd1 && right_on) begin
                o_slice[CHAR_W*j +: CHAR_W] = CH_BAR;
            end else if (j >= 1 && 5'(j) <= s5 && dash_on) begin
                o_slice[CHAR_W*j +: CHAR_W] = CH_DASH;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ssr_merge.sv -----
`default_nettype none

// Merge stage: holds the lane results of one row and hands them out
// one word per cycle unless stalled, leftmost digit first, through an output register.
module ssr_merge #(
    parameter int N_LANES = ssr_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_load,
    input  wire logic [N_LANES-1:0][ssr_pkg::SLICE_W-1:0] i_slices,
    input  wire logic [3:0]                            i_count,
    output      logic                                  o_load_ok,
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_stall,
    output      ssr_pkg::t_out_word                    o_out_word
);
    import ssr_pkg::*;

    localparam int IDX_W = (N_LANES > 1) ? $clog2(N_LANES) : 1;

    logic                             r_ln_v;
    logic [N_LANES-1:0][SLICE_W-1:0]  r_slc;
    logic [3:0]                       r_cnt;
    logic [IDX_W-1:0]                 r_idx;
    logic                             r_out_v;
    t_out_word                        r_out;

    logic out_free;
    logic emit;
    logic is_last;

    // Handshake between the held row and the output register
    always_comb begin
        out_free  = !r_out_v || !i_out_stall;
        emit      = r_ln_v && out_free;
        is_last   = (4'(r_idx) + 4'd1 == r_cnt);
        o_load_ok = !r_ln_v || (emit && is_last);
    end

    // Held row and digit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ln_v <= 1'b0;
            r_idx  <= '0;
        end else if (i_load && o_load_ok) begin
            r_ln_v <= 1'b1;
            r_idx  <= '0;
        end else if (emit) begin
            r_ln_v <= !is_last;
            r_idx  <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ok) begin
            r_slc <= i_slices;
            r_cnt <= i_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.slice_chars    <= r_slc[r_idx];
            r_out.digit_position <= 3'(r_idx);
            r_out.last_slice     <= is_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ----- rtl/scaled_seven_segment_row_render.sv -----
// Channel   Valid         Stall         Word
// in        i_in_valid    o_in_stall    i_in_word   (digit codes, count, row)
// out       o_out_valid   i_out_stall   o_out_word  (slice, position, last)
// cfg       i_cfg_we      -             i_cfg_wdata (glyph size)
//
// One row request gives one output word per digit in use (1 to 8; a zero
// count gives none), handed out in turn by the serialising merge stage. The
// first word passes the input register, held row and output register.
// A new row is taken while the previous one is still being handed out.
// Reset is synchronous; glyph size returns to 1. Output stall holds the
// output word and backs up into o_in_stall once the stages are full.
`default_nettype none

module scaled_seven_segment_row_render #(
    parameter int MAX_SIZE   = ssr_pkg::MAX_SIZE_DEF,
    parameter int MAX_DIGITS = ssr_pkg::MAX_DIGITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_wdata,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire ssr_pkg::t_in_word  i_in_word,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      ssr_pkg::t_out_word o_out_word
);
    import ssr_pkg::*;

    localparam int N_LANES = (MAX_DIGITS < CODE_DIGITS) ? MAX_DIGITS : CODE_DIGITS;

    logic [3:0]  r_size;
    logic        r_in_v;
    logic [31:0] r_codes;
    logic [3:0]  r_cnt;
    logic [4:0]  r_row;

    logic [3:0]  size_eff;
    logic [3:0]  cnt_sat;
    logic        load_ok;
    logic        in_take;
    logic [N_LANES-1:0][SLICE_W-1:0] lane_slices;

    // Glyph size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 4'd1;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    // Clamp scale and digit count
    always_comb begin
        if (r_size == 4'd0) begin
            size_eff = 4'd1;
        end else if (5'(r_size) > 5'(MAX_SIZE)) begin
            size_eff = 4'(MAX_SIZE);
        end else begin
            size_eff = r_size;
        end
        if (5'(i_in_word.digit_count) > 5'(N_LANES)) begin
            cnt_sat = 4'(N_LANES);
        end else begin
            cnt_sat = i_in_word.digit_count;
        end
    end

    // Input register
    assign o_in_stall = r_in_v && !load_ok;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_take) begin
            // a zero count gives no words at all
            r_in_v <= (cnt_sat != 4'd0);
        end else if (load_ok) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_codes <= i_in_word.digit_codes;
            r_cnt   <= cnt_sat;
            r_row   <= i_in_word.row_index;
        end
    end

    // Digit lanes
    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        ssr_lane u_lane (
            .i_code  (r_codes[4*l +: 4]),
            .i_size  (size_eff),
            .i_row   (r_row),
            .o_slice (lane_slices[l])
        );
    end

    // Merge and output
    ssr_merge #(
        .N_LANES (N_LANES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_in_v),
        .i_slices    (lane_slices),
        .i_count     (r_cnt),
        .o_load_ok   (load_ok),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ----- rtl/ssr_check.sv -----
`default_nettype none

`include "scaled_seven_segment_row_render_defines.svh"

// Port-level checks on the output channel
module ssr_check (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire ssr_pkg::t_out_word o_out_word
);
    import ssr_pkg::*;

    // a stalled word stays offered
    `SSR_ASSERT_NEXT(a_hold_valid, o_out_valid && i_out_stall, o_out_valid)

    // a stalled word keeps its payload
    `SSR_ASSERT_NEXT(a_hold_word, o_out_valid && i_out_stall, $stable(o_out_word))

    // the rest of a row follows with no gap
    `SSR_ASSERT_NEXT(a_row_gapless, o_out_valid && !i_out_stall && !o_out_word.last_slice, o_out_valid)

    // positions step by one within a row
    `SSR_ASSERT_NEXT(a_pos_step, o_out_valid && !i_out_stall && !o_out_word.last_slice, o_out_word.digit_position == $past(o_out_word.digit_position) + 3'd1)

    // the eighth digit always closes the row
    `SSR_ASSERT_NOW(a_pos_last, o_out_valid && o_out_word.digit_position == 3'd7, o_out_word.last_slice)

endmodule

bind scaled_seven_segment_row_render ssr_check u_ssr_check (.*);

`default_nettype wire
